FILE: design/ipsp_pkg.sv
// Shared constants and types of the instruction-pointer stride prefetcher.
package ipsp_pkg;

  localparam int TRACKER_ENTRIES  = 24;
  localparam int PREFETCH_COUNT   = 3;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int ADDRESS_BITS     = 48;

  localparam int TAG_W  = 8;
  localparam int OCC_W  = 7;
  localparam int MSHR_W = 7;

  localparam logic [MSHR_W-1:0] MSHR_RESET = MSHR_W'(16);

  // Commands broadcast from the controller to every tracker cell.
  typedef struct packed {
    logic alloc;
    logic train;
    logic promote;
  } cell_ctl_t;

  // Priority information rippled from one tracker cell to the next.
  typedef struct packed {
    logic hit_seen;
    logic victim_seen;
  } chain_t;

endpackage

FILE: design/ipsp_req_if.sv
// Demand access channel of the stride prefetcher.
interface ipsp_req_if #(
  parameter int ADDR_W = ipsp_pkg::ADDRESS_BITS
);
  logic                       valid;
  logic                       ready;
  logic [ADDR_W-1:0]          access_address;
  logic [ADDR_W-1:0]          instr_pointer;
  logic [ipsp_pkg::OCC_W-1:0] mshr_occupancy;

  modport source (
    output valid, access_address, instr_pointer, mshr_occupancy,
    input  ready
  );
  modport sink (
    input  valid, access_address, instr_pointer, mshr_occupancy,
    output ready
  );
endinterface

FILE: design/ipsp_pf_if.sv
// Prefetch request channel of the stride prefetcher.
interface ipsp_pf_if #(
  parameter int ADDR_W = ipsp_pkg::ADDRESS_BITS
);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] prefetch_address;
  logic              fill_near;
  logic              last_of_run;

  modport source (
    output valid, prefetch_address, fill_near, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, prefetch_address, fill_near, last_of_run,
    output ready
  );
endinterface

FILE: design/ipsp_cell.sv
// One tracker cell: tag, last line, last stride and recency rank of one entry.
module ipsp_cell #(
  parameter int LINE_W    = ipsp_pkg::ADDRESS_BITS - ipsp_pkg::LINE_OFFSET_BITS,
  parameter int RANK_W    = 5,
  parameter int LAST_RANK = 23,
  parameter int INDEX     = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ipsp_pkg::cell_ctl_t        ctl,
  input  logic                       pick,
  input  logic [ipsp_pkg::TAG_W-1:0] tag_in,
  input  logic [LINE_W-1:0]          line_in,
  input  logic [LINE_W:0]            stride_in,
  input  logic [RANK_W-1:0]          rank_ref,
  input  ipsp_pkg::chain_t           chain_in,
  output ipsp_pkg::chain_t           chain_out,
  output logic                       sel,
  output logic                       vic,
  output logic [LINE_W-1:0]          line,
  output logic [LINE_W:0]            stride,
  output logic [RANK_W-1:0]          rank
);

  logic [ipsp_pkg::TAG_W-1:0] tag;
  logic                       match;
  logic                       oldest;

  assign match  = (tag == tag_in);
  assign oldest = (rank == RANK_W'(LAST_RANK));

  assign sel                   = match & ~chain_in.hit_seen;
  assign vic                   = oldest & ~chain_in.victim_seen;
  assign chain_out.hit_seen    = chain_in.hit_seen | match;
  assign chain_out.victim_seen = chain_in.victim_seen | oldest;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag    <= '0;
      line   <= '0;
      stride <= '0;
      rank   <= RANK_W'(INDEX);
    end else begin
      if (pick && ctl.alloc) begin
        tag    <= tag_in;
        line   <= line_in;
        stride <= '0;
      end else if (pick && ctl.train) begin
        line   <= line_in;
        stride <= stride_in;
      end
      if (ctl.promote) begin
        if (pick) begin
          rank <= '0;
        end else if (rank < rank_ref) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
  end

endmodule

FILE: design/ipsp_issue.sv
// Prefetch run generator: steps along the stride within the page and drives the output register.
module ipsp_issue #(
  parameter int ADDR_W           = ipsp_pkg::ADDRESS_BITS,
  parameter int LINE_OFFSET_BITS = ipsp_pkg::LINE_OFFSET_BITS,
  parameter int PAGE_LINE_BITS   = ipsp_pkg::PAGE_OFFSET_BITS - ipsp_pkg::LINE_OFFSET_BITS,
  parameter int PREFETCH_COUNT   = ipsp_pkg::PREFETCH_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 neg,
  input  logic [PAGE_LINE_BITS-1:0]            mag,
  input  logic [ADDR_W-LINE_OFFSET_BITS-1:0]   line,
  input  logic                                 near,
  output logic                                 busy,
  ipsp_pf_if.source                            pf
);

  localparam int LINE_W = ADDR_W - LINE_OFFSET_BITS;
  localparam int BASE_W = LINE_W - PAGE_LINE_BITS;
  localparam int ACC_W  = PAGE_LINE_BITS + 2;
  localparam int K_W    = $clog2(PREFETCH_COUNT + 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(PREFETCH_COUNT);

  logic                      running;
  logic                      neg_q;
  logic [PAGE_LINE_BITS-1:0] mag_q;
  logic [BASE_W-1:0]         base_q;
  logic                      near_q;
  logic [ACC_W-1:0]          acc;
  logic [K_W-1:0]            k;

  logic                      out_valid;
  logic [ADDR_W-1:0]         out_address;
  logic                      out_near;
  logic                      out_last;

  logic [ACC_W-1:0] mag_ext;
  logic [ACC_W-1:0] off_ext;
  logic [ACC_W-1:0] first;
  logic [ACC_W-1:0] acc_next;
  logic             acc_ok;
  logic             next_ok;
  logic             last;
  logic             can_load;
  logic             emit;

  always_comb begin
    mag_ext  = {2'b00, mag_q};
    off_ext  = {2'b00, line[PAGE_LINE_BITS-1:0]};
    first    = neg ? (off_ext - {2'b00, mag}) : (off_ext + {2'b00, mag});
    acc_next = neg_q ? (acc - mag_ext) : (acc + mag_ext);
    acc_ok   = (acc[ACC_W-1:PAGE_LINE_BITS] == 2'b00);
    next_ok  = (acc_next[ACC_W-1:PAGE_LINE_BITS] == 2'b00);
    last     = (k == K_LAST) || !next_ok;
    can_load = !out_valid || pf.ready;
    emit     = running && acc_ok && can_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
      end else if (running && (!acc_ok || (emit && last))) begin
        running <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pf.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q  <= neg;
      mag_q  <= mag;
      base_q <= line[LINE_W-1:PAGE_LINE_BITS];
      near_q <= near;
      acc    <= first;
      k      <= K_W'(1);
    end else if (emit) begin
      acc <= acc_next;
      k   <= k + K_W'(1);
    end
    if (emit) begin
      out_address <= {base_q, acc[PAGE_LINE_BITS-1:0], {LINE_OFFSET_BITS{1'b0}}};
      out_near    <= near_q;
      out_last    <= last;
    end
  end

  assign busy                = running;
  assign pf.valid            = out_valid;
  assign pf.prefetch_address = out_address;
  assign pf.fill_near        = out_near;
  assign pf.last_of_run      = out_last;

endmodule

FILE: design/ip_stride_prefetcher.sv
// Top level of the instruction-pointer stride prefetcher.
// The access channel takes one demand access per transaction: byte address,
// instruction pointer (its low eight bits form the tag) and MSHR occupancy.
// The prefetch channel returns zero to PREFETCH_COUNT line-aligned addresses
// per access, the final one marked by last_of_run, each with a fill choice.
// The tracker table is a row of cells; a tag match and the LRU victim are
// found by priority signals that ripple from cell to cell.
// An access is looked up in the cycle after its transaction and the table is
// updated in the next; a started run then has the run generator drive its
// prefetches into the output register, one per cycle except when stalled.
// Without a run the block returns to idle after the update; with one it
// stays in issue until the run ends, also if its first step leaves the page.
// A stalled prefetch holds the run generator and so the access channel,
// except that a stall on the last prefetch of a run does not block the next
// access transaction.
// Reset is synchronous: every tracker takes tag zero, line zero, stride zero
// and a rank equal to its position, and mshr_entries returns to 16.
// mshr_entries is written through cfg_wr_en and cfg_wr_data; the user must do
// so only while idle, which the block itself leaves unchecked.
module ip_stride_prefetcher #(
  parameter int TRACKER_ENTRIES  = ipsp_pkg::TRACKER_ENTRIES,
  parameter int PREFETCH_COUNT   = ipsp_pkg::PREFETCH_COUNT,
  parameter int LINE_OFFSET_BITS = ipsp_pkg::LINE_OFFSET_BITS,
  parameter int PAGE_OFFSET_BITS = ipsp_pkg::PAGE_OFFSET_BITS,
  parameter int ADDRESS_BITS     = ipsp_pkg::ADDRESS_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  ipsp_req_if.sink                    access,
  ipsp_pf_if.source                   prefetch,
  input  logic                        cfg_wr_en,
  input  logic [ipsp_pkg::MSHR_W-1:0] cfg_wr_data
);

  localparam int LINE_W  = ADDRESS_BITS - LINE_OFFSET_BITS;
  localparam int DELTA_W = LINE_W + 1;
  localparam int PLB     = PAGE_OFFSET_BITS - LINE_OFFSET_BITS;
  localparam int RANK_W  = $clog2(TRACKER_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_ISSUE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ipsp_pkg::MSHR_W-1:0] mshr_entries;

  logic [LINE_W-1:0]          line_q;
  logic [ipsp_pkg::TAG_W-1:0] tag_q;
  logic [ipsp_pkg::OCC_W-1:0] occ_q;

  logic                       hit_q;
  logic [TRACKER_ENTRIES-1:0] pick_q;
  logic [LINE_W-1:0]          sel_line_q;
  logic [DELTA_W-1:0]         sel_stride_q;
  logic [RANK_W-1:0]          sel_rank_q;

  ipsp_pkg::chain_t           chain [TRACKER_ENTRIES+1];
  logic [TRACKER_ENTRIES-1:0] sel_vec;
  logic [TRACKER_ENTRIES-1:0] vic_vec;
  logic [LINE_W-1:0]          cell_line   [TRACKER_ENTRIES];
  logic [DELTA_W-1:0]         cell_stride [TRACKER_ENTRIES];
  logic [RANK_W-1:0]          cell_rank   [TRACKER_ENTRIES];

  logic [TRACKER_ENTRIES-1:0] pick_vec;
  logic [LINE_W-1:0]          mux_line;
  logic [DELTA_W-1:0]         mux_stride;
  logic [RANK_W-1:0]          mux_rank;

  ipsp_pkg::cell_ctl_t ctl;
  logic [DELTA_W-1:0]  delta;
  logic                delta_zero;
  logic                neg;
  logic [DELTA_W-1:0]  mag;
  logic                mag_small;
  logic                near;
  logic                start;
  logic                busy;

  assign chain[0] = '0;

  for (genvar i = 0; i < TRACKER_ENTRIES; i++) begin : g_cell
    ipsp_cell #(
      .LINE_W    (LINE_W),
      .RANK_W    (RANK_W),
      .LAST_RANK (TRACKER_ENTRIES - 1),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .pick      (pick_q[i]),
      .tag_in    (tag_q),
      .line_in   (line_q),
      .stride_in (delta),
      .rank_ref  (sel_rank_q),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .sel       (sel_vec[i]),
      .vic       (vic_vec[i]),
      .line      (cell_line[i]),
      .stride    (cell_stride[i]),
      .rank      (cell_rank[i])
    );
  end

  always_comb begin
    pick_vec   = chain[TRACKER_ENTRIES].hit_seen ? sel_vec : vic_vec;
    mux_line   = '0;
    mux_stride = '0;
    mux_rank   = '0;
    for (int i = 0; i < TRACKER_ENTRIES; i++) begin
      if (pick_vec[i]) begin
        mux_line   = mux_line | cell_line[i];
        mux_stride = mux_stride | cell_stride[i];
        mux_rank   = mux_rank | cell_rank[i];
      end
    end
  end

  always_comb begin
    delta      = {1'b0, line_q} - {1'b0, sel_line_q};
    delta_zero = (delta == '0);
    neg        = delta[DELTA_W-1];
    mag        = neg ? (~delta + DELTA_W'(1)) : delta;
    mag_small  = (mag[DELTA_W-1:PLB] == '0);
    near       = (occ_q < (mshr_entries >> 1));

    ctl.alloc   = (state == ST_UPDATE) && !hit_q;
    ctl.train   = (state == ST_UPDATE) && hit_q && !delta_zero;
    ctl.promote = ctl.alloc || ctl.train;
    start       = ctl.train && (delta == sel_stride_q) && mag_small;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (access.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = start ? ST_ISSUE : ST_IDLE;
      end
      ST_ISSUE: begin
        if (!busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign access.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mshr_entries <= ipsp_pkg::MSHR_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        mshr_entries <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      line_q <= access.access_address[ADDRESS_BITS-1:LINE_OFFSET_BITS];
      tag_q  <= access.instr_pointer[ipsp_pkg::TAG_W-1:0];
      occ_q  <= access.mshr_occupancy;
    end
    if (state == ST_LOOKUP) begin
      hit_q        <= chain[TRACKER_ENTRIES].hit_seen;
      pick_q       <= pick_vec;
      sel_line_q   <= mux_line;
      sel_stride_q <= mux_stride;
      sel_rank_q   <= mux_rank;
    end
  end

  ipsp_issue #(
    .ADDR_W           (ADDRESS_BITS),
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .PAGE_LINE_BITS   (PLB),
    .PREFETCH_COUNT   (PREFETCH_COUNT)
  ) u_issue (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .neg   (neg),
    .mag   (mag[PLB-1:0]),
    .line  (line_q),
    .near  (near),
    .busy  (busy),
    .pf    (prefetch)
  );

endmodule

FILE: design/ipsp_checker.sv
// Port-level checker for the stride prefetcher, bound to the top level.
module ipsp_checker #(
  parameter int ADDR_W = ipsp_pkg::ADDRESS_BITS
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_address,
  input logic              out_last
);

  // An accepted access keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("access accepted in two consecutive cycles");

  // After an access, lookup and update come before any new prefetch.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid) ##1 !$rose(out_valid)
                               ##1 !$rose(out_valid))
    else $error("prefetch appeared too early after an access");

  // While a run is unfinished the access channel stays closed.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("access accepted in the middle of a prefetch run");

  // A stalled prefetch transaction keeps its address.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_address)))
    else $error("stalled prefetch changed or vanished");

endmodule

bind ip_stride_prefetcher ipsp_checker #(
  .ADDR_W (ADDRESS_BITS)
) u_ipsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (access.valid),
  .in_ready    (access.ready),
  .out_valid   (prefetch.valid),
  .out_ready   (prefetch.ready),
  .out_address (prefetch.prefetch_address),
  .out_last    (prefetch.last_of_run)
);
